/* rtl/core/sparse_polynomial_multiply_macros.svh */
// Assertion macros shared by the RTL. Each expects i_clk and i_rst_n in scope.
`ifndef SPARSE_POLYNOMIAL_MULTIPLY_MACROS_SVH
`define SPARSE_POLYNOMIAL_MULTIPLY_MACROS_SVH

`ifndef SYNTHESIS

// condition holds at every clock edge out of reset
`define SPM_ASSERT(lbl, cond) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (cond)) \
        else $error("spm assertion failed");

// antecedent implies consequent in the same cycle
`define SPM_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("spm assertion failed");

// antecedent implies consequent in the next cycle
`define SPM_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("spm assertion failed");

`else

`define SPM_ASSERT(lbl, cond)
`define SPM_ASSERT_IMP(lbl, ante, cons)
`define SPM_ASSERT_NEXT(lbl, ante, cons)

`endif

`endif

/* rtl/core/spm_pkg.sv */
package spm_pkg;

    localparam int FUNC_W     = 2;
    localparam int COEF_W     = 16;
    localparam int EXP_W      = 5;
    localparam int OUT_COEF_W = 40;
    localparam int OUT_EXP_W  = 6;
    localparam int PROD_W     = 2 * COEF_W;

    localparam int MAX_TERMS_DEF = 16;
    localparam int MAX_EXP_DEF   = 31;

    // transaction function codes
    localparam logic [FUNC_W-1:0] FN_STORE  = 2'd0;
    localparam logic [FUNC_W-1:0] FN_APPLY  = 2'd1;
    localparam logic [FUNC_W-1:0] FN_FINISH = 2'd2;

    typedef enum logic [2:0] {
        S_IDLE,
        S_BIN_RD,
        S_ACC,
        S_SCAN_RD,
        S_SCAN_CHK,
        S_FLUSH
    } t_state;

    typedef struct packed {
        logic mul_en;    // capture the product of the two coefficients
        logic acc_zero;  // bin was never written since the last finish
    } t_mac_ctrl;

endpackage

/* rtl/core/spm_stream_if.sv */
interface spm_in_if;
    logic                                valid;
    logic                                ready;
    logic        [spm_pkg::FUNC_W-1:0]   func;
    logic signed [spm_pkg::COEF_W-1:0]   term_coef;
    logic        [spm_pkg::EXP_W-1:0]    term_exp;

    modport source (output valid, func, term_coef, term_exp, input ready);
    modport sink   (input valid, func, term_coef, term_exp, output ready);
endinterface

interface spm_out_if;
    logic                                 valid;
    logic                                 ready;
    logic signed [spm_pkg::OUT_COEF_W-1:0] out_coef;
    logic        [spm_pkg::OUT_EXP_W-1:0]  out_exp;
    logic                                 last;
    logic                                 overflow;

    modport source (output valid, out_coef, out_exp, last, overflow, input ready);
    modport sink   (input valid, out_coef, out_exp, last, overflow, output ready);
endinterface

/* rtl/core/spm_ram.sv */
module spm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

/* rtl/core/spm_mac.sv */
module spm_mac (
    input  logic                                  i_clk,
    input  spm_pkg::t_mac_ctrl                    i_ctrl,
    input  logic signed [spm_pkg::COEF_W-1:0]     i_a,
    input  logic signed [spm_pkg::COEF_W-1:0]     i_b,
    input  logic        [spm_pkg::OUT_COEF_W-1:0] i_acc,
    output logic        [spm_pkg::OUT_COEF_W-1:0] o_sum
);
    import spm_pkg::*;

    logic signed [PROD_W-1:0]     r_prod;
    logic        [OUT_COEF_W-1:0] acc_in;
    logic        [OUT_COEF_W-1:0] prod_ext;

    always_ff @(posedge i_clk) begin
        if (i_ctrl.mul_en) begin
            r_prod <= i_a * i_b;
        end
    end

    // bins wrap modulo 2^40
    assign acc_in   = i_ctrl.acc_zero ? '0 : i_acc;
    assign prod_ext = {{(OUT_COEF_W - PROD_W){r_prod[PROD_W-1]}}, r_prod};
    assign o_sum    = acc_in + prod_ext;

endmodule

/* rtl/core/sparse_polynomial_multiply.sv */
// Sparse polynomial multiplier. Store transactions (func 0) load first-polynomial
// terms, up to MAX_TERMS; more set the overflow flag. An apply transaction (func 1)
// walks the N stored terms: one multiplier and a read-modify-write of the exponent
// bin memory handle one stored term at a time, in a bin-read and an accumulate state.
// A finish transaction (func 2) scans all 2*MAX_EXP+1 bins, each in a read and a
// check state, waiting while the output side stalls, emitting the nonzero bins in
// ascending exponent order (or a single zero term), then clears all state at once.
// Terms with an exponent above MAX_EXP are ignored. The input is not ready while an
// apply or finish is in progress.
`include "sparse_polynomial_multiply_macros.svh"

module sparse_polynomial_multiply #(
    parameter int MAX_TERMS = spm_pkg::MAX_TERMS_DEF,
    parameter int MAX_EXP   = spm_pkg::MAX_EXP_DEF
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    spm_in_if.sink       i_in,
    spm_out_if.source    o_out
);
    import spm_pkg::*;

    localparam int CW       = $clog2(MAX_TERMS + 1);
    localparam int TIW      = (MAX_TERMS > 1) ? $clog2(MAX_TERMS) : 1;
    localparam int TERM_W   = EXP_W + COEF_W;
    localparam int NUM_BINS = 2 * MAX_EXP + 1;
    localparam int BW       = $clog2(NUM_BINS);

    t_state                  r_state, n_state;
    logic [CW-1:0]           r_count, n_count;
    logic                    r_drop, n_drop;
    logic [CW-1:0]           r_i, n_i;
    logic signed [COEF_W-1:0] r_coef, n_coef;
    logic [EXP_W-1:0]        r_exp, n_exp;
    logic [BW-1:0]           r_bin, n_bin;
    logic [BW-1:0]           r_b, n_b;
    logic [NUM_BINS-1:0]     r_bin_vld, n_bin_vld;
    logic                    r_pend_v, n_pend_v;
    logic [OUT_COEF_W-1:0]   r_pend_coef, n_pend_coef;
    logic [BW-1:0]           r_pend_exp, n_pend_exp;
    logic                    r_out_vld, n_out_vld;
    logic [OUT_COEF_W-1:0]   r_out_coef, n_out_coef;
    logic [OUT_EXP_W-1:0]    r_out_exp, n_out_exp;
    logic                    r_out_last, n_out_last;
    logic                    r_out_ovf, n_out_ovf;

    logic                    in_ready;
    logic                    exp_ok;
    logic                    full;
    logic                    out_free;
    logic                    adv;
    logic [CW-1:0]           i_inc;
    logic                    term_we;
    logic [TIW-1:0]          term_raddr;
    logic [TERM_W-1:0]       term_rdata;
    logic [OUT_EXP_W-1:0]    bin_sum_wide;
    logic [BW-1:0]           bin_sum;
    logic                    bin_we;
    logic [BW-1:0]           bin_raddr;
    logic [OUT_COEF_W-1:0]   bin_rdata;
    logic [OUT_COEF_W-1:0]   scan_val;
    logic [OUT_COEF_W-1:0]   mac_sum;
    t_mac_ctrl               mac_ctrl;

    assign exp_ok   = i_in.term_exp <= EXP_W'(MAX_EXP);
    assign full     = r_count == CW'(MAX_TERMS);
    assign out_free = !r_out_vld || o_out.ready;
    assign i_inc    = r_i + CW'(1);
    assign term_we  = in_ready && i_in.valid && (i_in.func == FN_STORE) && exp_ok && !full;

    assign bin_sum_wide = OUT_EXP_W'(term_rdata[TERM_W-1 -: EXP_W]) + OUT_EXP_W'(r_exp);
    assign bin_sum      = bin_sum_wide[BW-1:0];
    assign scan_val     = r_bin_vld[r_b] ? bin_rdata : '0;

    spm_ram #(
        .WIDTH (TERM_W),
        .DEPTH (MAX_TERMS)
    ) u_term_ram (
        .i_clk   (i_clk),
        .i_we    (term_we),
        .i_waddr (r_count[TIW-1:0]),
        .i_wdata ({i_in.term_exp, i_in.term_coef}),
        .i_raddr (term_raddr),
        .o_rdata (term_rdata)
    );

    spm_ram #(
        .WIDTH (OUT_COEF_W),
        .DEPTH (NUM_BINS)
    ) u_bin_ram (
        .i_clk   (i_clk),
        .i_we    (bin_we),
        .i_waddr (r_bin),
        .i_wdata (mac_sum),
        .i_raddr (bin_raddr),
        .o_rdata (bin_rdata)
    );

    spm_mac u_mac (
        .i_clk  (i_clk),
        .i_ctrl (mac_ctrl),
        .i_a    (term_rdata[COEF_W-1:0]),
        .i_b    (r_coef),
        .i_acc  (bin_rdata),
        .o_sum  (mac_sum)
    );

    always_comb begin
        n_state     = r_state;
        n_count     = r_count;
        n_drop      = r_drop;
        n_i         = r_i;
        n_coef      = r_coef;
        n_exp       = r_exp;
        n_bin       = r_bin;
        n_b         = r_b;
        n_bin_vld   = r_bin_vld;
        n_pend_v    = r_pend_v;
        n_pend_coef = r_pend_coef;
        n_pend_exp  = r_pend_exp;
        n_out_vld   = r_out_vld && !o_out.ready;
        n_out_coef  = r_out_coef;
        n_out_exp   = r_out_exp;
        n_out_last  = r_out_last;
        n_out_ovf   = r_out_ovf;
        in_ready    = 1'b0;
        term_raddr  = '0;
        bin_raddr   = r_b;
        bin_we      = 1'b0;
        mac_ctrl    = '0;
        adv         = 1'b0;

        unique case (r_state)
            S_IDLE: begin
                in_ready = 1'b1;
                if (i_in.valid) begin
                    case (i_in.func)
                        FN_STORE: begin
                            if (exp_ok) begin
                                if (full) begin
                                    n_drop = 1'b1;
                                end else begin
                                    n_count = r_count + CW'(1);
                                end
                            end
                        end
                        FN_APPLY: begin
                            if (exp_ok && r_count != '0) begin
                                n_coef  = i_in.term_coef;
                                n_exp   = i_in.term_exp;
                                n_i     = '0;
                                n_state = S_BIN_RD;
                            end
                        end
                        FN_FINISH: begin
                            n_b     = '0;
                            n_state = S_SCAN_RD;
                        end
                        default: ;
                    endcase
                end
            end
            S_BIN_RD: begin
                mac_ctrl.mul_en = 1'b1;
                bin_raddr       = bin_sum;
                n_bin           = bin_sum;
                n_state         = S_ACC;
            end
            S_ACC: begin
                mac_ctrl.acc_zero = !r_bin_vld[r_bin];
                bin_we            = 1'b1;
                n_bin_vld[r_bin]  = 1'b1;
                // prefetch the next stored term
                term_raddr        = i_inc[TIW-1:0];
                if (i_inc == r_count) begin
                    n_state = S_IDLE;
                end else begin
                    n_i     = i_inc;
                    n_state = S_BIN_RD;
                end
            end
            S_SCAN_RD: begin
                n_state = S_SCAN_CHK;
            end
            S_SCAN_CHK: begin
                // hold one nonzero bin back so the final one can carry last
                if (scan_val != '0) begin
                    if (!r_pend_v) begin
                        n_pend_v    = 1'b1;
                        n_pend_coef = scan_val;
                        n_pend_exp  = r_b;
                        adv         = 1'b1;
                    end else if (out_free) begin
                        n_out_vld   = 1'b1;
                        n_out_coef  = r_pend_coef;
                        n_out_exp   = OUT_EXP_W'(r_pend_exp);
                        n_out_last  = 1'b0;
                        n_out_ovf   = r_drop;
                        n_pend_coef = scan_val;
                        n_pend_exp  = r_b;
                        adv         = 1'b1;
                    end
                end else begin
                    adv = 1'b1;
                end
                if (adv) begin
                    if (r_b == BW'(NUM_BINS - 1)) begin
                        n_state = S_FLUSH;
                    end else begin
                        n_b     = r_b + BW'(1);
                        n_state = S_SCAN_RD;
                    end
                end
            end
            S_FLUSH: begin
                if (out_free) begin
                    n_out_vld  = 1'b1;
                    n_out_coef = r_pend_v ? r_pend_coef : '0;
                    n_out_exp  = r_pend_v ? OUT_EXP_W'(r_pend_exp) : '0;
                    n_out_last = 1'b1;
                    n_out_ovf  = r_drop;
                    n_bin_vld  = '0;
                    n_count    = '0;
                    n_drop     = 1'b0;
                    n_pend_v   = 1'b0;
                    n_state    = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_count   <= '0;
            r_drop    <= 1'b0;
            r_bin_vld <= '0;
            r_pend_v  <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_count   <= n_count;
            r_drop    <= n_drop;
            r_bin_vld <= n_bin_vld;
            r_pend_v  <= n_pend_v;
            r_out_vld <= n_out_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_i         <= n_i;
        r_coef      <= n_coef;
        r_exp       <= n_exp;
        r_bin       <= n_bin;
        r_b         <= n_b;
        r_pend_coef <= n_pend_coef;
        r_pend_exp  <= n_pend_exp;
        r_out_coef  <= n_out_coef;
        r_out_exp   <= n_out_exp;
        r_out_last  <= n_out_last;
        r_out_ovf   <= n_out_ovf;
    end

    assign i_in.ready     = in_ready;
    assign o_out.valid    = r_out_vld;
    assign o_out.out_coef = r_out_coef;
    assign o_out.out_exp  = r_out_exp;
    assign o_out.last     = r_out_last;
    assign o_out.overflow = r_out_ovf;

    `SPM_ASSERT(a_count_cap, r_count <= CW'(MAX_TERMS))
    `SPM_ASSERT_IMP(a_pend_in_finish, r_pend_v, (r_state == S_SCAN_RD || r_state == S_SCAN_CHK || r_state == S_FLUSH))
    `SPM_ASSERT_NEXT(a_finish_clears, r_state == S_FLUSH && out_free, r_bin_vld == '0 && r_count == '0 && o_out.valid && o_out.last)

endmodule

/* tb/sparse_polynomial_multiply_tb.sv */
`timescale 1ns / 1ps

module sparse_polynomial_multiply_tb;
    import spm_pkg::*;

    localparam logic [FUNC_W-1:0] FN_UNUSED = 2'd3;
    localparam int NUM_BINS    = 2 * MAX_EXP_DEF + 1;
    localparam int TERM_TARGET = 370;
    localparam int STALL_LIMIT = 2000;
    localparam int RX_HOLD     = 300;
    localparam int DRAIN_WAIT  = 200;

    typedef struct {
        logic        [FUNC_W-1:0] func;
        logic signed [COEF_W-1:0] coef;
        logic        [EXP_W-1:0]  pow;
    } t_term;

    typedef struct {
        t_term term;
        bit    drain_first;  // hold until every outstanding product term is back
        bit    hold_rx;      // start the long receiver hold-off when offered
    } t_job;

    typedef struct {
        logic signed [OUT_COEF_W-1:0] coef;
        logic        [OUT_EXP_W-1:0]  pow;
        logic                         last;
        logic                         overflow;
    } t_prod_term;

    logic i_clk;
    logic i_rst_n;

    spm_in_if  in_bus ();
    spm_out_if out_bus ();

    sparse_polynomial_multiply dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_bus),
        .o_out   (out_bus)
    );

    // predictor state
    logic signed [COEF_W-1:0]     held_coef [MAX_TERMS_DEF];
    logic        [EXP_W-1:0]      held_pow  [MAX_TERMS_DEF];
    int                           held_cnt = 0;
    logic                         held_dropped = 1'b0;
    logic        [OUT_COEF_W-1:0] prod_bins [NUM_BINS];

    t_job       terms_to_send[$];
    t_prod_term product_terms_due[$];

    int   terms_queued = 0;
    int   terms_taken = 0;
    int   fail_count = 0;
    int   stuck_cycles = 0;
    logic in_fired = 1'b0;
    logic quiet;
    logic hold_trigger = 1'b0;
    logic hold_started = 1'b0;
    int   hold_left = 0;

    // no idling on either side through one stretch of the run
    assign quiet = (terms_taken >= 200) && (terms_taken < 280);

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    function automatic void multiply_model(input t_term t);
        t_prod_term               batch[$];
        t_prod_term               pt;
        logic signed [PROD_W-1:0] prod;
        logic [OUT_EXP_W-1:0]     b;
        case (t.func)
            FN_STORE: begin
                if (held_cnt < MAX_TERMS_DEF) begin
                    held_coef[held_cnt] = t.coef;
                    held_pow[held_cnt]  = t.pow;
                    held_cnt++;
                end else begin
                    held_dropped = 1'b1;
                end
            end
            FN_APPLY: begin
                for (int i = 0; i < held_cnt; i++) begin
                    b = {1'b0, held_pow[i]} + {1'b0, t.pow};
                    prod = held_coef[i] * t.coef;
                    prod_bins[b] = prod_bins[b] +
                        {{(OUT_COEF_W - PROD_W){prod[PROD_W-1]}}, prod};
                end
            end
            FN_FINISH: begin
                for (int i = 0; i < NUM_BINS; i++) begin
                    if (prod_bins[i] != '0) begin
                        pt.coef     = prod_bins[i];
                        pt.pow      = OUT_EXP_W'(i);
                        pt.last     = 1'b0;
                        pt.overflow = held_dropped;
                        batch.push_back(pt);
                    end
                end
                if (batch.size() == 0) begin
                    pt.coef     = '0;
                    pt.pow      = '0;
                    pt.last     = 1'b0;
                    pt.overflow = held_dropped;
                    batch.push_back(pt);
                end
                batch[batch.size() - 1].last = 1'b1;
                foreach (batch[i]) product_terms_due.push_back(batch[i]);
                foreach (prod_bins[i]) prod_bins[i] = '0;
                held_cnt     = 0;
                held_dropped = 1'b0;
            end
            default: ;
        endcase
    endfunction

    function automatic void queue_term(input logic [FUNC_W-1:0] func,
                                       input logic signed [COEF_W-1:0] coef,
                                       input logic [EXP_W-1:0] pow,
                                       input bit drain_first = 1'b0,
                                       input bit hold_rx = 1'b0);
        t_job j;
        j.term.func     = func;
        j.term.coef     = coef;
        j.term.pow      = pow;
        j.drain_first   = drain_first;
        j.hold_rx       = hold_rx;
        terms_to_send.push_back(j);
        if (func != FN_UNUSED) terms_queued++;
    endfunction

    function automatic logic signed [COEF_W-1:0] pick_coef();
        case ($urandom_range(0, 9))
            0: return 16'sh7fff;
            1: return 16'sh8000;
            2: return -16'sd1;
            3: return 16'sd1;
            default: return COEF_W'($urandom);
        endcase
    endfunction

    function automatic logic [EXP_W-1:0] pick_pow(input int span);
        case ($urandom_range(0, 9))
            0: return '0;
            1: return EXP_W'(span);
            default: return EXP_W'($urandom_range(0, span));
        endcase
    endfunction

    // input driver
    always @(negedge i_clk) begin
        logic offer;
        if (!i_rst_n) begin
            in_bus.valid <= 1'b0;
        end else if (!in_bus.valid || in_fired) begin
            offer = (terms_to_send.size() != 0) && (quiet || $urandom_range(0, 99) >= 15);
            if (offer && terms_to_send[0].drain_first && product_terms_due.size() != 0)
                offer = 1'b0;
            if (offer) begin
                in_bus.valid     <= 1'b1;
                in_bus.func      <= terms_to_send[0].term.func;
                in_bus.term_coef <= terms_to_send[0].term.coef;
                in_bus.term_exp  <= terms_to_send[0].term.pow;
                if (terms_to_send[0].hold_rx) hold_trigger <= 1'b1;
            end else begin
                in_bus.valid <= 1'b0;
            end
        end
    end

    // output ready, with one long hold-off while the sender keeps offering
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            out_bus.ready <= 1'b0;
        end else if (hold_trigger && !hold_started) begin
            hold_started  <= 1'b1;
            hold_left     <= RX_HOLD;
            out_bus.ready <= 1'b0;
        end else if (hold_left != 0) begin
            hold_left     <= hold_left - 1;
            out_bus.ready <= 1'b0;
        end else begin
            out_bus.ready <= quiet || $urandom_range(0, 99) >= 15;
        end
    end

    // monitor: predict on accepted input, check accepted output
    always @(posedge i_clk) begin
        t_term      t;
        t_prod_term want;
        logic       out_fired;
        in_fired  = i_rst_n && in_bus.valid && in_bus.ready;
        out_fired = i_rst_n && out_bus.valid && out_bus.ready;
        if (in_fired) begin
            t.func = in_bus.func;
            t.coef = in_bus.term_coef;
            t.pow  = in_bus.term_exp;
            multiply_model(t);
            void'(terms_to_send.pop_front());
            terms_taken++;
        end
        if (out_fired) begin
            if (product_terms_due.size() == 0) begin
                $display("%0t: unexpected product term: expected none, got coef %0d exp %0d last %b overflow %b",
                         $time, out_bus.out_coef, out_bus.out_exp, out_bus.last,
                         out_bus.overflow);
                fail_count++;
            end else begin
                want = product_terms_due.pop_front();
                if (out_bus.out_coef !== want.coef || out_bus.out_exp !== want.pow ||
                    out_bus.last !== want.last || out_bus.overflow !== want.overflow) begin
                    $display("%0t: product term mismatch: expected coef %0d exp %0d last %b overflow %b, got coef %0d exp %0d last %b overflow %b",
                             $time, want.coef, want.pow, want.last, want.overflow,
                             out_bus.out_coef, out_bus.out_exp, out_bus.last,
                             out_bus.overflow);
                    fail_count++;
                end
            end
        end
        if (in_fired || out_fired || !i_rst_n)
            stuck_cycles <= 0;
        else
            stuck_cycles <= stuck_cycles + 1;
    end

    initial begin
        wait (stuck_cycles >= STALL_LIMIT);
        $display("tb: failure");
        $finish;
    end

    initial begin
        int n_store;
        int n_apply;
        int span;
        int seq;
        i_rst_n          = 1'b0;
        in_bus.valid     = 1'b0;
        in_bus.func      = FN_STORE;
        in_bus.term_coef = '0;
        in_bus.term_exp  = '0;
        out_bus.ready    = 1'b0;
        foreach (prod_bins[i]) prod_bins[i] = '0;

        // empty product right out of reset
        queue_term(FN_FINISH, 16'sd0, 5'd0);
        // extremes of coefficient and exponent, reaching the top bin;
        // the receiver holds off from here so the finish below backs up
        queue_term(FN_STORE, 16'sh7fff, 5'd31, 1'b0, 1'b1);
        queue_term(FN_STORE, 16'sh8000, 5'd0);
        queue_term(FN_STORE, -16'sd1, 5'd17);
        queue_term(FN_UNUSED, -16'sd1, 5'd31);
        queue_term(FN_APPLY, 16'sh8000, 5'd31);
        queue_term(FN_APPLY, 16'sh7fff, 5'd0);
        queue_term(FN_APPLY, 16'sd0, 5'd5);
        queue_term(FN_FINISH, 16'sh5a5a, 5'd21);
        // products that cancel to a zero bin
        queue_term(FN_STORE, 16'sd5, 5'd1);
        queue_term(FN_STORE, -16'sd7, 5'd3);
        queue_term(FN_APPLY, 16'sd3, 5'd2);
        queue_term(FN_APPLY, -16'sd3, 5'd2);
        queue_term(FN_APPLY, 16'sd1, 5'd0);
        queue_term(FN_UNUSED, 16'sh7fff, 5'd0);
        queue_term(FN_FINISH, -16'sd1, 5'd31);

        // full store, bin 0 accumulates to 2^39 and wraps negative
        for (int i = 0; i < MAX_TERMS_DEF; i++)
            queue_term(FN_STORE, 16'sh8000, 5'd0, i == 0);
        for (int i = 0; i < 32; i++) queue_term(FN_APPLY, 16'sh8000, 5'd0);
        queue_term(FN_APPLY, 16'sd1, 5'd31);
        queue_term(FN_FINISH, 16'sd0, 5'd0);
        // one store too many, bin 0 wraps all the way to zero
        for (int i = 0; i <= MAX_TERMS_DEF; i++) queue_term(FN_STORE, 16'sh8000, 5'd0);
        for (int i = 0; i < 64; i++) queue_term(FN_APPLY, 16'sh8000, 5'd0);
        queue_term(FN_FINISH, 16'sd0, 5'd0);

        seq = 0;
        while (terms_queued < TERM_TARGET) begin
            n_store = ($urandom_range(0, 5) == 0) ? $urandom_range(14, 20)
                                                  : $urandom_range(0, 8);
            n_apply = $urandom_range(0, 6);
            span    = $urandom_range(0, 1) ? 31 : 3;
            for (int i = 0; i < n_store; i++) begin
                queue_term(FN_STORE, pick_coef(), pick_pow(span),
                           i == 0 && seq % 8 == 7);
                if ($urandom_range(0, 14) == 0)
                    queue_term(FN_UNUSED, COEF_W'($urandom), EXP_W'($urandom));
            end
            for (int i = 0; i < n_apply; i++) begin
                queue_term(FN_APPLY, pick_coef(), pick_pow(span));
                // a late store only counts for the applies that follow it
                if ($urandom_range(0, 14) == 0)
                    queue_term(FN_STORE, pick_coef(), pick_pow(span));
            end
            queue_term(FN_FINISH, COEF_W'($urandom), EXP_W'($urandom));
            seq++;
        end

        repeat (10) @(negedge i_clk);
        i_rst_n <= 1'b1;

        while (terms_to_send.size() != 0 || product_terms_due.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_WAIT) @(posedge i_clk);

        if (fail_count == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
